### rtl/complex_2x2_matrix_alu_core_assert.svh
// Assertion macros for the complex 2x2 matrix ALU core.
// Included by the top level; no other dependencies.
`ifndef COMPLEX_2X2_MATRIX_ALU_CORE_ASSERT_SVH
`define COMPLEX_2X2_MATRIX_ALU_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CMALU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define CMALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cmalu_pkg.sv
// Shared types, operation codes and helpers for the complex 2x2 matrix ALU.
// No dependencies.
package cmalu_pkg;

	localparam int CW  = 24;        // bits per real or imaginary part
	localparam int PKW = 2 * CW;    // packed complex element

	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_SUB   = 3'd1;
	localparam logic [2:0] ACT_MUL   = 3'd2;
	localparam logic [2:0] ACT_SCALE = 3'd3;
	localparam logic [2:0] ACT_CONJ  = 3'd4;
	localparam logic [2:0] ACT_DET   = 3'd5;
	localparam logic [2:0] ACT_TRACE = 3'd6;

	localparam logic [CW-1:0] CMAX_C = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN_C = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [2:0]     action;
		logic [PKW-1:0] a00;
		logic [PKW-1:0] a01;
		logic [PKW-1:0] a10;
		logic [PKW-1:0] a11;
		logic [PKW-1:0] b00;
		logic [PKW-1:0] b01;
		logic [PKW-1:0] b10;
		logic [PKW-1:0] b11;
		logic [PKW-1:0] scalar;
	} req_t;

	typedef struct packed {
		logic [PKW-1:0] r00;
		logic [PKW-1:0] r01;
		logic [PKW-1:0] r10;
		logic [PKW-1:0] r11;
		logic           overflow;
	} res_t;

	typedef struct packed {
		logic signed [CW-1:0] re;
		logic signed [CW-1:0] im;
	} cpx_t;

	// add/sub/negate result, one guard bit
	typedef struct packed {
		logic signed [CW:0] re;
		logic signed [CW:0] im;
	} lin_t;

	// per-element control carried beside the operands
	typedef struct packed {
		logic use_mult;   // take the product sum, else the linear value
		logic neg_hi;     // subtract the second complex product
	} ctl_t;

	function automatic cpx_t unpack(input logic [PKW-1:0] p);
		cpx_t c;
		c.re = p[PKW-1:CW];
		c.im = p[CW-1:0];
		return c;
	endfunction

	function automatic logic [CW:0] sext1(input logic [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

endpackage

### rtl/cmalu_opsel.sv
// Stage 1: decodes the action and steers operands to the multiplier array;
// also forms the add, subtract, conjugate and trace values. Uses cmalu_pkg.
module cmalu_opsel (
	input  logic              clk,
	input  logic              en,
	input  cmalu_pkg::req_t   req,
	output cmalu_pkg::cpx_t   x0_s1 [4],
	output cmalu_pkg::cpx_t   y0_s1 [4],
	output cmalu_pkg::cpx_t   x1_s1 [4],
	output cmalu_pkg::cpx_t   y1_s1 [4],
	output cmalu_pkg::lin_t   lin_s1 [4],
	output cmalu_pkg::ctl_t   ctl_s1 [4]
);
	import cmalu_pkg::*;

	cpx_t a [4];
	cpx_t b [4];
	cpx_t s;
	cpx_t x0 [4];
	cpx_t y0 [4];
	cpx_t x1 [4];
	cpx_t y1 [4];
	lin_t lin [4];
	ctl_t ctl [4];

	always_comb begin
		a[0] = unpack(req.a00);
		a[1] = unpack(req.a01);
		a[2] = unpack(req.a10);
		a[3] = unpack(req.a11);
		b[0] = unpack(req.b00);
		b[1] = unpack(req.b01);
		b[2] = unpack(req.b10);
		b[3] = unpack(req.b11);
		s    = unpack(req.scalar);
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			x0[k]  = '0;
			y0[k]  = '0;
			x1[k]  = '0;
			y1[k]  = '0;
			lin[k] = '0;
			ctl[k] = '0;
		end
		unique case (req.action)
			ACT_ADD: begin
				for (int k = 0; k < 4; k++) begin
					lin[k].re = sext1(a[k].re) + sext1(b[k].re);
					lin[k].im = sext1(a[k].im) + sext1(b[k].im);
				end
			end
			ACT_SUB: begin
				for (int k = 0; k < 4; k++) begin
					lin[k].re = sext1(a[k].re) - sext1(b[k].re);
					lin[k].im = sext1(a[k].im) - sext1(b[k].im);
				end
			end
			ACT_MUL: begin
				// row of A times column of B
				for (int k = 0; k < 4; k++) begin
					x0[k] = a[k & 2];
					x1[k] = a[(k & 2) + 1];
					y0[k] = b[k & 1];
					y1[k] = b[(k & 1) + 2];
					ctl[k].use_mult = 1'b1;
				end
			end
			ACT_SCALE: begin
				for (int k = 0; k < 4; k++) begin
					x0[k] = a[k];
					y0[k] = s;
					ctl[k].use_mult = 1'b1;
				end
			end
			ACT_CONJ: begin
				// transpose swaps the off-diagonal elements
				for (int k = 0; k < 4; k++) begin
					lin[k].re = sext1(a[((k & 1) << 1) | (k >> 1)].re);
					lin[k].im = (CW + 1)'(0) - sext1(a[((k & 1) << 1) | (k >> 1)].im);
				end
			end
			ACT_DET: begin
				// a00*a11 - a01*a10; other elements stay zero
				x0[0] = a[0];
				y0[0] = a[3];
				x1[0] = a[1];
				y1[0] = a[2];
				ctl[0].neg_hi = 1'b1;
				for (int k = 0; k < 4; k++) begin
					ctl[k].use_mult = 1'b1;
				end
			end
			ACT_TRACE: begin
				lin[0].re = sext1(a[0].re) + sext1(a[3].re);
				lin[0].im = sext1(a[0].im) + sext1(a[3].im);
			end
			default: begin
				// unused code: all-zero result
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1  <= x0;
			y0_s1  <= y0;
			x1_s1  <= x1;
			y1_s1  <= y1;
			lin_s1 <= lin;
			ctl_s1 <= ctl;
		end
	end

endmodule

### rtl/cmalu_cmul.sv
// Stage 2: one complex multiply as four registered real products, each
// truncated by an arithmetic shift of FRAC_BITS. Uses cmalu_pkg.
module cmalu_cmul #(
	parameter int FRAC_BITS = 20,
	localparam int PW = 2 * cmalu_pkg::CW - FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 en,
	input  cmalu_pkg::cpx_t      x,
	input  cmalu_pkg::cpx_t      y,
	output logic signed [PW-1:0] rr_s2,
	output logic signed [PW-1:0] ii_s2,
	output logic signed [PW-1:0] ri_s2,
	output logic signed [PW-1:0] ir_s2
);
	import cmalu_pkg::*;

	logic signed [2*CW-1:0] rr;
	logic signed [2*CW-1:0] ii;
	logic signed [2*CW-1:0] ri;
	logic signed [2*CW-1:0] ir;

	assign rr = (x.re * y.re) >>> FRAC_BITS;
	assign ii = (x.im * y.im) >>> FRAC_BITS;
	assign ri = (x.re * y.im) >>> FRAC_BITS;
	assign ir = (x.im * y.re) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s2 <= rr[PW-1:0];
			ii_s2 <= ii[PW-1:0];
			ri_s2 <= ri[PW-1:0];
			ir_s2 <= ir[PW-1:0];
		end
	end

endmodule

### rtl/cmalu_pack.sv
// Stage 4: saturates each summed component, packs the result matrix and
// raises the overflow flag. Uses cmalu_pkg.
module cmalu_pack #(
	parameter int FRAC_BITS = 20,
	localparam int PW = 2 * cmalu_pkg::CW - FRAC_BITS,
	localparam int SW = (PW + 2 > cmalu_pkg::CW + 1) ? PW + 2 : cmalu_pkg::CW + 1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [SW-1:0] sum_re [4],
	input  logic signed [SW-1:0] sum_im [4],
	output cmalu_pkg::res_t      res_s4
);
	import cmalu_pkg::*;

	localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic [PKW-1:0] r [4];
	logic           ovf;
	res_t           res;

	always_comb begin
		logic [CW-1:0] re_c;
		logic [CW-1:0] im_c;
		ovf = 1'b0;
		for (int k = 0; k < 4; k++) begin
			re_c = sum_re[k][CW-1:0];
			im_c = sum_im[k][CW-1:0];
			if (sum_re[k] > SMAX) begin
				re_c = CMAX_C;
				ovf  = 1'b1;
			end else if (sum_re[k] < SMIN) begin
				re_c = CMIN_C;
				ovf  = 1'b1;
			end
			if (sum_im[k] > SMAX) begin
				im_c = CMAX_C;
				ovf  = 1'b1;
			end else if (sum_im[k] < SMIN) begin
				im_c = CMIN_C;
				ovf  = 1'b1;
			end
			r[k] = {re_c, im_c};
		end
		res.r00      = r[0];
		res.r01      = r[1];
		res.r10      = r[2];
		res.r11      = r[3];
		res.overflow = ovf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res;
		end
	end

endmodule

### rtl/complex_2x2_matrix_alu_core.sv
// Complex 2x2 matrix ALU: add, subtract, matrix product, scale, conjugate
// transpose, determinant and trace on Q-format complex elements (real part in
// the upper half of each 48-bit element, imaginary in the lower half). It is a
// four-stage pipeline: operand select, a bank of 32 registered multipliers,
// four-term summation, then saturation into the result register. Result valid
// rises once the request has passed the stage 1 to stage 4 registers. One
// request is taken every cycle while results are drained; the multiplier bank
// sets the stage depth. A stall on the result side holds each full stage whose
// later stages are all full, while items behind it still move into empty stages.
`include "complex_2x2_matrix_alu_core_assert.svh"

module complex_2x2_matrix_alu_core #(
	parameter int FRAC_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cmalu_pkg::req_t   req,
	output logic              res_valid,
	input  logic              res_ready,
	output cmalu_pkg::res_t   res
);
	import cmalu_pkg::*;

	localparam int PW = 2 * CW - FRAC_BITS;
	localparam int SW = (PW + 2 > CW + 1) ? PW + 2 : CW + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// a stage advances when the one after it is empty or advancing
	assign en4       = !v_s4 || res_ready;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_ready = en1;
	assign res_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	cpx_t x0_s1 [4];
	cpx_t y0_s1 [4];
	cpx_t x1_s1 [4];
	cpx_t y1_s1 [4];
	lin_t lin_s1 [4];
	ctl_t ctl_s1 [4];

	cmalu_opsel u_opsel (
		.clk    (clk),
		.en     (en1),
		.req    (req),
		.x0_s1  (x0_s1),
		.y0_s1  (y0_s1),
		.x1_s1  (x1_s1),
		.y1_s1  (y1_s1),
		.lin_s1 (lin_s1),
		.ctl_s1 (ctl_s1)
	);

	lin_t lin_s2 [4];
	ctl_t ctl_s2 [4];

	always_ff @(posedge clk) begin
		if (en2) begin
			lin_s2 <= lin_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	logic signed [PW-1:0] rr0_s2 [4], ii0_s2 [4], ri0_s2 [4], ir0_s2 [4];
	logic signed [PW-1:0] rr1_s2 [4], ii1_s2 [4], ri1_s2 [4], ir1_s2 [4];
	logic signed [SW-1:0] sum_re_s3 [4];
	logic signed [SW-1:0] sum_im_s3 [4];

	for (genvar k = 0; k < 4; k++) begin : g_elem
		logic signed [SW-1:0] lo_re, lo_im, hi_re, hi_im, re, im;

		cmalu_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_lo (
			.clk   (clk),
			.en    (en2),
			.x     (x0_s1[k]),
			.y     (y0_s1[k]),
			.rr_s2 (rr0_s2[k]),
			.ii_s2 (ii0_s2[k]),
			.ri_s2 (ri0_s2[k]),
			.ir_s2 (ir0_s2[k])
		);

		cmalu_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_hi (
			.clk   (clk),
			.en    (en2),
			.x     (x1_s1[k]),
			.y     (y1_s1[k]),
			.rr_s2 (rr1_s2[k]),
			.ii_s2 (ii1_s2[k]),
			.ri_s2 (ri1_s2[k]),
			.ir_s2 (ir1_s2[k])
		);

		always_comb begin
			lo_re = SW'(rr0_s2[k]) - SW'(ii0_s2[k]);
			lo_im = SW'(ri0_s2[k]) + SW'(ir0_s2[k]);
			hi_re = SW'(rr1_s2[k]) - SW'(ii1_s2[k]);
			hi_im = SW'(ri1_s2[k]) + SW'(ir1_s2[k]);
			if (!ctl_s2[k].use_mult) begin
				re = SW'(lin_s2[k].re);
				im = SW'(lin_s2[k].im);
			end else if (ctl_s2[k].neg_hi) begin
				re = lo_re - hi_re;
				im = lo_im - hi_im;
			end else begin
				re = lo_re + hi_re;
				im = lo_im + hi_im;
			end
		end

		always_ff @(posedge clk) begin
			if (en3) begin
				sum_re_s3[k] <= re;
				sum_im_s3[k] <= im;
			end
		end
	end

	cmalu_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
		.clk    (clk),
		.en     (en4),
		.sum_re (sum_re_s3),
		.sum_im (sum_im_s3),
		.res_s4 (res)
	);

	// some component of the result sits at a saturation limit
	logic sat_seen;

	always_comb begin
		logic [PKW-1:0] e [4];
		e[0] = res.r00;
		e[1] = res.r01;
		e[2] = res.r10;
		e[3] = res.r11;
		sat_seen = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (e[k][PKW-1:CW] == CMAX_C || e[k][PKW-1:CW] == CMIN_C ||
			    e[k][CW-1:0] == CMAX_C || e[k][CW-1:0] == CMIN_C) begin
				sat_seen = 1'b1;
			end
		end
	end

	`CMALU_ASSERT_NOW(a_ovf_has_limit, clk, arst_n, res_valid && res.overflow, sat_seen,
		"overflow flagged without a saturated component")
	`CMALU_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req_valid && req_ready, v_s1,
		"accepted request did not enter stage 1")
	`CMALU_ASSERT_NEXT(a_stall_holds, clk, arst_n, v_s3 && v_s4 && !res_ready,
		v_s3 && v_s4, "stalled pipeline dropped an item")

endmodule
